FILE: rtl/core/s5scan_pkg.sv
package s5scan_pkg;

    // Default number of history cells
    localparam int WINDOW_DEF = 32;
    // A candidate name is judged once it lies this many bytes back
    localparam int LOOKAHEAD  = 20;
    // Shortest lag still judged when the table ends early
    localparam int MIN_LAG    = 4;
    // Bytes seen by one judge: two prefix bytes plus offsets 0..LOOKAHEAD
    localparam int SPAN       = LOOKAHEAD + 3;
    // Number of judges, one per lag MIN_LAG..LOOKAHEAD
    localparam int NUM_JUDGE  = LOOKAHEAD - MIN_LAG + 1;
    // Sleep type field position in the PM1 control word
    localparam int SLP_SHIFT  = 10;

    typedef logic [7:0] t_byte;

    // Name characters
    localparam t_byte CH_UNDER = 8'h5F;
    localparam t_byte CH_S     = 8'h53;
    localparam t_byte CH_5     = 8'h35;
    localparam t_byte CH_ROOT  = 8'h5C;

    // AML opcodes
    localparam t_byte OP_NAME    = 8'h08;
    localparam t_byte OP_PACKAGE = 8'h12;
    localparam t_byte OP_ZERO    = 8'h00;
    localparam t_byte OP_ONE     = 8'h01;
    localparam t_byte OP_BYTE    = 8'h0A;
    localparam t_byte OP_WORD    = 8'h0B;
    localparam t_byte OP_DWORD   = 8'h0C;
    localparam t_byte OP_QWORD   = 8'h0E;

    // One history cell: byte plus "belongs to the current table"
    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_cell;

    // Chain control shared by all cells
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // Outcome of judging one candidate position
    typedef struct packed {
        logic  ok;
        t_byte a;
        t_byte b;
    } t_verdict;

endpackage

FILE: rtl/core/s5scan_if.sv
// Byte stream channel
interface s5scan_in_if;
    logic                valid;
    logic                ready;
    s5scan_pkg::t_byte   data_byte;
    logic                last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// Result channel
interface s5scan_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] sleep_ctl_a;
    logic [15:0] sleep_ctl_b;

    modport source (output valid, found, sleep_ctl_a, sleep_ctl_b, input ready);
    modport sink   (input valid, found, sleep_ctl_a, sleep_ctl_b, output ready);
endinterface

FILE: rtl/core/aml_s5_sleep_type_scanner_unit.sv
// _S5_ sleep type scanner.
// i_in takes the AML body of a DSDT, one byte per item, last_byte set on the
// final byte. o_res gives at most one item per table: found = 1 with both
// sleep values (low byte of each package integer, shifted left 10) at the
// first matching _S5_ package, or found = 0 with zero values on the last
// byte when none matched. After a match the rest of the table is absorbed.
// Bytes move through a chain of WINDOW cells; a candidate is judged when it
// lies 20 bytes back, and on the last byte every pending position 4..20 back
// is judged at once, earliest first.
// Throughput: one byte per cycle, unless stalled as below. The byte that
// completes a result is first registered in the chain, the judges see it
// combinationally, and the verdict then lands in the output register that
// drives o_res.valid.
// Stall: while o_res holds an untaken item, input keeps flowing until the
// next result is due; then i_in.ready drops until the output register frees.
// Reset clears the chain, the match flag and the output register; the block
// is ready for input as soon as reset is released. A last byte also returns the
// chain to its empty state, so the next byte starts a new table.
module aml_s5_sleep_type_scanner_unit #(
    parameter int WINDOW = s5scan_pkg::WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    s5scan_in_if.sink           i_in,
    s5scan_out_if.source        o_res
);

    localparam int NJ = s5scan_pkg::NUM_JUDGE;

    s5scan_pkg::t_cell    w_cell [WINDOW];
    s5scan_pkg::t_cell    w_link [WINDOW];
    s5scan_pkg::t_cell_ctl w_ctl;
    logic [WINDOW-1:0]    w_valid_vec;
    s5scan_pkg::t_byte    w_win [NJ][s5scan_pkg::SPAN];
    logic [2:0]           w_pre [NJ];
    s5scan_pkg::t_verdict w_verdict [NJ];
    s5scan_pkg::t_verdict w_any;
    s5scan_pkg::t_verdict w_pick;
    logic                 w_fire;
    logic                 w_adv;
    logic                 w_accept;

    logic                 r_pend;
    logic                 r_last;
    logic                 r_answer;
    logic                 r_out_valid;
    logic                 r_found;
    logic [15:0]          r_sleep_a;
    logic [15:0]          r_sleep_b;

    // Handshake and chain control
    assign w_adv       = !r_pend || !w_fire || !r_out_valid;
    assign i_in.ready  = w_adv;
    assign w_accept    = i_in.valid && w_adv;
    assign w_ctl.shift = w_accept;
    assign w_ctl.clear = w_adv && r_pend && r_last;

    // Cell chain, newest byte in cell 0
    genvar gk, gl, gi;
    generate
        for (gk = 0; gk < WINDOW; gk++) begin : g_cell
            if (gk == 0) begin : g_head
                assign w_link[gk] = '{valid: 1'b1, data: i_in.data_byte};
            end else begin : g_body
                assign w_link[gk] = '{valid: w_cell[gk-1].valid & ~w_ctl.clear,
                                      data:  w_cell[gk-1].data};
            end
            s5scan_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_prev  (w_link[gk]),
                .o_cell  (w_cell[gk])
            );
            assign w_valid_vec[gk] = w_cell[gk].valid;
        end

        // One judge per lag, taps wired to fixed cells
        for (gl = 0; gl < NJ; gl++) begin : g_judge
            localparam int LAGJ = s5scan_pkg::MIN_LAG + gl;
            for (gi = 0; gi < s5scan_pkg::SPAN; gi++) begin : g_tap
                localparam int IDX = LAGJ + 2 - gi;
                if (IDX >= 0) begin : g_live
                    assign w_win[gl][gi] = w_cell[IDX].data;
                end else begin : g_none
                    assign w_win[gl][gi] = '0;
                end
            end
            assign w_pre[gl] = {w_cell[LAGJ + 2].valid, w_cell[LAGJ + 1].valid,
                                w_cell[LAGJ].valid};
            s5scan_judge #(.LAG(LAGJ)) u_judge (
                .i_win       (w_win[gl]),
                .i_pre_valid (w_pre[gl]),
                .o_verdict   (w_verdict[gl])
            );
        end
    endgenerate

    // Earliest start wins at table end (largest lag)
    always_comb begin
        w_any = '0;
        for (int j = 0; j < NJ; j++) begin
            if (w_verdict[j].ok) begin
                w_any = w_verdict[j];
            end
        end
        w_pick = r_last ? w_any : w_verdict[NJ-1];
        w_fire = r_pend && !r_answer && (w_pick.ok || r_last);
    end

    // Evaluation stage and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_answer    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_pend <= w_accept;
                if (r_pend) begin
                    r_answer <= r_last ? 1'b0 : (r_answer | w_fire);
                end
            end
            if (w_fire && w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item flag and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_in.last_byte;
        end
        if (w_fire && w_adv) begin
            r_found   <= w_pick.ok;
            r_sleep_a <= w_pick.ok ? 16'({8'h00, w_pick.a} << s5scan_pkg::SLP_SHIFT) : '0;
            r_sleep_b <= w_pick.ok ? 16'({8'h00, w_pick.b} << s5scan_pkg::SLP_SHIFT) : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_found;
    assign o_res.sleep_ctl_a = r_sleep_a;
    assign o_res.sleep_ctl_b = r_sleep_b;

    // Table members always form an unbroken run from the newest cell
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec >> 1) & ~w_valid_vec) == '0)
        else $error("cell valid bits not contiguous");

    // Input only stalls behind a pending result and a full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_res.valid && r_pend))
        else $error("input stalled without a blocked result");

    // A miss carries zero sleep values
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |-> (o_res.sleep_ctl_a == '0 && o_res.sleep_ctl_b == '0))
        else $error("miss result with nonzero values");

    // Table end empties the chain when no new byte follows at once
    a_table_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.clear && !w_accept) |=> (w_valid_vec == '0))
        else $error("chain not empty after table end");

endmodule

FILE: rtl/core/s5scan_cell.sv
// One history cell of the byte chain
module s5scan_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  s5scan_pkg::t_cell_ctl i_ctl,
    input  s5scan_pkg::t_cell     i_prev,
    output s5scan_pkg::t_cell     o_cell
);

    logic              r_valid;
    s5scan_pkg::t_byte r_data;

    // Table membership: taken from the neighbor on shift, dropped at table end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev.valid;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end
    end

    // Byte payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_prev.data;
        end
    end

    assign o_cell = '{valid: r_valid, data: r_data};

endmodule

FILE: rtl/core/s5scan_judge.sv
// Checks one candidate position for NameOp, _S5_, PackageOp and two integers.
// i_win[i] holds the byte at offset i-2 from the candidate name.
module s5scan_judge #(
    parameter int LAG = s5scan_pkg::LOOKAHEAD
) (
    input  s5scan_pkg::t_byte    i_win [s5scan_pkg::SPAN],
    input  logic [2:0]           i_pre_valid,
    output s5scan_pkg::t_verdict o_verdict
);

    // Bytes usable from the candidate on
    localparam int BOUND = LAG + 1;
    localparam int N_LEN = 5;
    // Integer encodings: opcode plus data, lengths 1, 2, 3, 5, 9
    localparam int LEN_TAB [N_LEN] = '{1, 2, 3, 5, 9};

    typedef struct packed {
        logic              ok;
        logic [2:0]        sel;
        s5scan_pkg::t_byte val;
    } t_int_dec;

    // Decode one integer whose opcode sits at offset k
    function automatic t_int_dec dec_int(input s5scan_pkg::t_byte op,
                                         input s5scan_pkg::t_byte dat,
                                         input int k);
        t_int_dec d;
        d = '0;
        if (k < BOUND) begin
            case (op)
                s5scan_pkg::OP_ZERO: begin
                    d.ok  = 1'b1;
                    d.sel = 3'd0;
                    d.val = 8'h00;
                end
                s5scan_pkg::OP_ONE: begin
                    d.ok  = 1'b1;
                    d.sel = 3'd0;
                    d.val = 8'h01;
                end
                s5scan_pkg::OP_BYTE: begin
                    d.ok  = (k + 1 < BOUND);
                    d.sel = 3'd1;
                    d.val = dat;
                end
                s5scan_pkg::OP_WORD: begin
                    d.ok  = (k + 3 <= BOUND);
                    d.sel = 3'd2;
                    d.val = dat;
                end
                s5scan_pkg::OP_DWORD: begin
                    d.ok  = (k + 1 < BOUND);
                    d.sel = 3'd3;
                    d.val = dat;
                end
                s5scan_pkg::OP_QWORD: begin
                    d.ok  = (k + 1 < BOUND);
                    d.sel = 3'd4;
                    d.val = dat;
                end
                default: d = '0;
            endcase
        end
        return d;
    endfunction

    t_int_dec   w_da [4];
    t_int_dec   w_db [4][N_LEN];
    t_int_dec   w_a;
    t_int_dec   w_b;
    logic [1:0] w_pl;
    logic       w_name_ok;
    logic       w_pre_ok;
    logic       w_pkg_ok;
    logic       w_len_ok;

    // Every possible integer position decoded at a fixed tap
    genvar gp, gj;
    generate
        for (gp = 0; gp < 4; gp++) begin : g_pl
            localparam int KA = 7 + gp;
            assign w_da[gp] = dec_int(i_win[KA + 2], i_win[KA + 3], KA);
            for (gj = 0; gj < N_LEN; gj++) begin : g_len
                localparam int KB = KA + LEN_TAB[gj];
                assign w_db[gp][gj] = dec_int(i_win[KB + 2], i_win[KB + 3], KB);
            end
        end
    endgenerate

    // Pick decodes by PkgLength size and first integer length
    always_comb begin
        w_pl      = i_win[7][7:6];
        w_a       = w_da[w_pl];
        w_b       = w_db[w_pl][w_a.sel];
        w_name_ok = (i_win[2] == s5scan_pkg::CH_UNDER) && (i_win[3] == s5scan_pkg::CH_S) &&
                    (i_win[4] == s5scan_pkg::CH_5) && (i_win[5] == s5scan_pkg::CH_UNDER);
        w_pre_ok  = (i_pre_valid[1] && (i_win[1] == s5scan_pkg::OP_NAME)) ||
                    (i_pre_valid[2] && (i_win[0] == s5scan_pkg::OP_NAME) &&
                     (i_win[1] == s5scan_pkg::CH_ROOT));
        w_pkg_ok  = (i_win[6] == s5scan_pkg::OP_PACKAGE);
        // PkgLength bytes and NumElements must lie inside the table
        w_len_ok  = (6 + int'(w_pl)) < BOUND;
        o_verdict.ok = i_pre_valid[0] && w_name_ok && w_pre_ok && w_pkg_ok && w_len_ok &&
                       w_a.ok && w_b.ok;
        o_verdict.a  = w_a.val;
        o_verdict.b  = w_b.val;
    end

endmodule

FILE: dv/tb_aml_s5_sleep_type_scanner_unit.sv
module tb_aml_s5_sleep_type_scanner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import s5scan_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int RAND_ITEMS   = 900;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DIR_N        = 34;

    // one result item of the scanner
    typedef struct packed {
        logic        found;
        logic [15:0] sleep_ctl_a;
        logic [15:0] sleep_ctl_b;
    } s5_result_t;

    // where the expectation of a stimulus item comes from
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_RESULT
    } row_exp_t;

    typedef struct packed {
        t_byte      data;
        logic       last;
        row_exp_t   kind;
        s5_result_t typed;
    } dir_row_t;

    typedef struct {
        t_byte      data;
        logic       last;
        row_exp_t   kind;
        s5_result_t typed;
        int         gap;
    } aml_item_t;

    localparam s5_result_t NO_RES   = '0;
    localparam s5_result_t S5_FC_D0 = '{1'b1, 16'hFC00, 16'hD000};

    logic i_clk = 1'b0;
    logic i_rst_n;

    s5scan_in_if  in_ch ();
    s5scan_out_if res_ch ();

    aml_s5_sleep_type_scanner_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: byte history newest first, fill count, table answered
    t_byte hist [WIN];
    int    hist_fill;
    bit    table_done;

    s5_result_t pending_res [$];
    aml_item_t  aml_stream [$];
    t_byte      tbl_bytes [$];
    dir_row_t   dir_rows [DIR_N];

    int   err_cnt    = 0;
    int   cycle_cnt  = 0;
    int   send_idx   = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    logic nxt_vld;

    function automatic void hist_clear();
        for (int i = 0; i < WIN; i++) hist[i] = '0;
        hist_fill  = 0;
        table_done = 1'b0;
    endfunction

    // byte at offset k from a candidate that lies lag bytes back
    function automatic t_byte hist_at(int lag, int k);
        int idx;
        idx = lag - k;
        if (idx < 0 || idx >= WIN) return '0;
        return hist[idx];
    endfunction

    // one package integer; only its low data byte is kept
    function automatic bit take_int(int lag, int bound, inout int k, output t_byte val);
        t_byte op;
        val = '0;
        if (k >= bound) return 1'b0;
        op = hist_at(lag, k);
        k++;
        case (op)
            OP_ZERO: val = 8'h00;
            OP_ONE:  val = 8'h01;
            OP_BYTE: begin
                if (k >= bound) return 1'b0;
                val = hist_at(lag, k);
                k++;
            end
            OP_WORD: begin
                if (bound - k < 2) return 1'b0;
                val = hist_at(lag, k);
                k += 2;
            end
            OP_DWORD, OP_QWORD: begin
                if (k >= bound) return 1'b0;
                val = hist_at(lag, k);
                k += (op == OP_DWORD) ? 4 : 8;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // full _S5_ package check of the candidate lag bytes back
    function automatic bit s5_match_at(int lag, output t_byte a, output t_byte b);
        int    bound;
        int    k;
        bit    pre_name;
        bit    pre_root;
        t_byte pkg_len;
        a     = '0;
        b     = '0;
        bound = lag + 1;
        if (lag + 1 > hist_fill) return 1'b0;
        if (bound <= 4) return 1'b0;
        if (hist_at(lag, 0) != CH_UNDER || hist_at(lag, 1) != CH_S ||
            hist_at(lag, 2) != CH_5 || hist_at(lag, 3) != CH_UNDER) return 1'b0;
        // prefix bytes only count if they belong to this table
        pre_name = (lag + 2 <= hist_fill) && hist_at(lag, -1) == OP_NAME;
        pre_root = (lag + 3 <= hist_fill) && hist_at(lag, -2) == OP_NAME &&
                   hist_at(lag, -1) == CH_ROOT;
        if (!pre_name && !pre_root) return 1'b0;
        if (hist_at(lag, 4) != OP_PACKAGE) return 1'b0;
        k = 5;
        if (k >= bound) return 1'b0;
        pkg_len = hist_at(lag, k);
        k += 1 + int'(pkg_len[7:6]);
        if (k >= bound) return 1'b0;
        k++;
        if (!take_int(lag, bound, k, a)) return 1'b0;
        if (!take_int(lag, bound, k, b)) return 1'b0;
        return 1'b1;
    endfunction

    // advance the predictor by one byte; returns 1 when a result is due
    function automatic bit s5_scan_byte(t_byte d, logic last, output s5_result_t res);
        t_byte a;
        t_byte b;
        bit    ok;
        bit    due;
        int    lag;
        ok  = 1'b0;
        due = 1'b0;
        res = '0;
        a   = '0;
        b   = '0;
        for (int i = WIN - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = d;
        if (hist_fill < WIN) hist_fill++;
        if (!table_done) begin
            // on the last byte every pending position is judged, earliest first
            if (last) begin
                for (lag = LOOKAHEAD; lag >= MIN_LAG && !ok; lag--)
                    ok = s5_match_at(lag, a, b);
            end else begin
                ok = s5_match_at(LOOKAHEAD, a, b);
            end
            if (ok || last) begin
                res.found       = ok;
                res.sleep_ctl_a = ok ? ({8'h00, a} << SLP_SHIFT) : 16'h0000;
                res.sleep_ctl_b = ok ? ({8'h00, b} << SLP_SHIFT) : 16'h0000;
                table_done      = 1'b1;
                due             = 1'b1;
            end
        end
        if (last) hist_clear();
        return due;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random byte biased toward the codes the scanner cares about
    function automatic t_byte noise_byte();
        case ($urandom_range(0, 11))
            0:       return OP_NAME;
            1:       return CH_ROOT;
            2:       return CH_UNDER;
            3:       return CH_S;
            4:       return CH_5;
            5:       return OP_PACKAGE;
            6:       return OP_ZERO;
            7:       return OP_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_item(t_byte d, logic last, row_exp_t kind, s5_result_t typed);
        aml_item_t it;
        it.data  = d;
        it.last  = last;
        it.kind  = kind;
        it.typed = typed;
        // every fourth stretch of items runs back to back
        it.gap   = ((aml_stream.size() / 128) % 4 == 3) ? 0 : pick_gap();
        aml_stream.push_back(it);
    endtask

    task automatic add_int();
        int sel;
        sel = $urandom_range(0, 13);
        case (sel)
            0, 1: tbl_bytes.push_back(OP_ZERO);
            2, 3: tbl_bytes.push_back(OP_ONE);
            4, 5: begin
                tbl_bytes.push_back(OP_BYTE);
                tbl_bytes.push_back(8'($urandom));
            end
            6, 7: begin
                tbl_bytes.push_back(OP_WORD);
                repeat (2) tbl_bytes.push_back(8'($urandom));
            end
            8, 9: begin
                tbl_bytes.push_back(OP_DWORD);
                repeat (4) tbl_bytes.push_back(8'($urandom));
            end
            10, 11: begin
                tbl_bytes.push_back(OP_QWORD);
                repeat (8) tbl_bytes.push_back(8'($urandom));
            end
            default: tbl_bytes.push_back(8'($urandom));
        endcase
    endtask

    // _S5_ package with random content, now and then broken
    task automatic add_package();
        t_byte pkg_len;
        t_byte name [4];
        name = '{CH_UNDER, CH_S, CH_5, CH_UNDER};
        case ($urandom_range(0, 5))
            0, 1, 2: tbl_bytes.push_back(OP_NAME);
            3, 4: begin
                tbl_bytes.push_back(OP_NAME);
                tbl_bytes.push_back(CH_ROOT);
            end
            default: tbl_bytes.push_back(noise_byte());
        endcase
        for (int i = 0; i < 4; i++)
            tbl_bytes.push_back(($urandom_range(0, 19) == 0) ? noise_byte() : name[i]);
        tbl_bytes.push_back(($urandom_range(0, 19) == 0) ? noise_byte() : OP_PACKAGE);
        pkg_len = 8'($urandom);
        tbl_bytes.push_back(pkg_len);
        repeat (int'(pkg_len[7:6])) tbl_bytes.push_back(8'($urandom));
        tbl_bytes.push_back(8'($urandom));
        add_int();
        add_int();
    endtask

    // one random table; last mark on its final byte
    task automatic add_table();
        int keep;
        tbl_bytes = {};
        if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 40)) tbl_bytes.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(0, 6)) tbl_bytes.push_back(noise_byte());
                add_package();
            end
            repeat ($urandom_range(0, 25)) tbl_bytes.push_back(noise_byte());
            // table cut short, often inside the package
            if ($urandom_range(0, 3) == 0) begin
                keep = $urandom_range(1, tbl_bytes.size());
                while (tbl_bytes.size() > keep) void'(tbl_bytes.pop_back());
            end
        end
        for (int i = 0; i < tbl_bytes.size(); i++)
            push_item(tbl_bytes[i], i == tbl_bytes.size() - 1, EXP_MODEL, NO_RES);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
        err_cnt++;
    endtask

    // input driver, predictor and result checker
    always @(posedge i_clk) begin
        s5_result_t pred;
        s5_result_t want;
        aml_item_t  cur;
        bit         due;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            res_ch.ready <= 1'b0;
        end else begin
            // input side
            nxt_vld = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                cur = aml_stream[send_idx];
                due = s5_scan_byte(cur.data, cur.last, pred);
                case (cur.kind)
                    EXP_MODEL:  if (due) pending_res.push_back(pred);
                    EXP_RESULT: pending_res.push_back(cur.typed);
                    default: ;
                endcase
                nxt_vld = 1'b0;
                send_idx++;
                gap_left = (send_idx < aml_stream.size()) ? aml_stream[send_idx].gap : 0;
            end
            if (!nxt_vld) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (send_idx < aml_stream.size()) begin
                    nxt_vld = 1'b1;
                    in_ch.data_byte <= aml_stream[send_idx].data;
                    in_ch.last_byte <= aml_stream[send_idx].last;
                end
            end
            in_ch.valid <= nxt_vld;

            // result side
            if (res_ch.valid && res_ch.ready) begin
                if (pending_res.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b a=%h b=%h",
                        res_ch.found, res_ch.sleep_ctl_a, res_ch.sleep_ctl_b));
                end else begin
                    want = pending_res.pop_front();
                    if (res_ch.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b",
                            res_ch.found, want.found));
                    if (res_ch.sleep_ctl_a !== want.sleep_ctl_a)
                        report_mismatch($sformatf("sleep_ctl_a %h, want %h",
                            res_ch.sleep_ctl_a, want.sleep_ctl_a));
                    if (res_ch.sleep_ctl_b !== want.sleep_ctl_b)
                        report_mismatch($sformatf("sleep_ctl_b %h, want %h",
                            res_ch.sleep_ctl_b, want.sleep_ctl_b));
                end
            end
            // receiver stalls, none in one stretch out of four
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (cycle_cnt[9:8] != 2'b11 && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("aml_s5_sleep_type_scanner_unit regression: fail");
            $finish;
        end
    end

    initial begin
        // directed tables
        dir_rows = '{
            // one-byte table, name opcode as its only byte: not found
            '{8'h08, 1'b1, EXP_RESULT, NO_RES},
            // name at the very start: the previous table's 08 does not count
            '{8'h5F, 1'b0, EXP_MODEL, NO_RES},
            '{8'h53, 1'b0, EXP_MODEL, NO_RES},
            '{8'h35, 1'b0, EXP_MODEL, NO_RES},
            '{8'h5F, 1'b0, EXP_MODEL, NO_RES},
            '{8'h12, 1'b0, EXP_MODEL, NO_RES},
            '{8'h00, 1'b0, EXP_MODEL, NO_RES},
            '{8'h02, 1'b0, EXP_MODEL, NO_RES},
            '{8'h00, 1'b0, EXP_MODEL, NO_RES},
            '{8'h01, 1'b1, EXP_RESULT, NO_RES},
            // 08 5C prefix, two-byte PkgLength, ByteConst FF, WordConst 1234
            '{8'h08, 1'b0, EXP_MODEL, NO_RES},
            '{8'h5C, 1'b0, EXP_MODEL, NO_RES},
            '{8'h5F, 1'b0, EXP_MODEL, NO_RES},
            '{8'h53, 1'b0, EXP_MODEL, NO_RES},
            '{8'h35, 1'b0, EXP_MODEL, NO_RES},
            '{8'h5F, 1'b0, EXP_MODEL, NO_RES},
            '{8'h12, 1'b0, EXP_MODEL, NO_RES},
            '{8'h40, 1'b0, EXP_MODEL, NO_RES},
            '{8'h3F, 1'b0, EXP_MODEL, NO_RES},
            '{8'h02, 1'b0, EXP_MODEL, NO_RES},
            '{8'h0A, 1'b0, EXP_MODEL, NO_RES},
            '{8'hFF, 1'b0, EXP_MODEL, NO_RES},
            '{8'h0B, 1'b0, EXP_MODEL, NO_RES},
            '{8'h34, 1'b0, EXP_MODEL, NO_RES},
            '{8'h12, 1'b0, EXP_MODEL, NO_RES},
            '{8'hFF, 1'b0, EXP_MODEL, NO_RES},
            '{8'h00, 1'b0, EXP_MODEL, NO_RES},
            '{8'hFF, 1'b0, EXP_MODEL, NO_RES},
            '{8'h00, 1'b0, EXP_MODEL, NO_RES},
            '{8'hFF, 1'b0, EXP_MODEL, NO_RES},
            '{8'h00, 1'b0, EXP_MODEL, NO_RES},
            '{8'hFF, 1'b0, EXP_MODEL, NO_RES},
            // name now 20 bytes back: match before the end of the table
            '{8'h00, 1'b0, EXP_RESULT, S5_FC_D0},
            // rest of a matched table is absorbed, last byte gives nothing
            '{8'h5A, 1'b1, EXP_NONE, NO_RES}
        };
        hist_clear();
        for (int i = 0; i < DIR_N; i++)
            push_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].kind,
                      dir_rows[i].typed);
        while (aml_stream.size() < DIR_N + RAND_ITEMS) add_table();
        gap_left = aml_stream[0].gap;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        res_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (send_idx < aml_stream.size() || pending_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("aml_s5_sleep_type_scanner_unit regression: pass");
        end else begin
            $display("aml_s5_sleep_type_scanner_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/s5scan_pkg.sv
rtl/core/s5scan_if.sv
rtl/core/s5scan_cell.sv
rtl/core/s5scan_judge.sv
rtl/core/aml_s5_sleep_type_scanner_unit.sv
dv/tb_aml_s5_sleep_type_scanner_unit.sv
